@@ sv/vpcc_pkg.sv @@
package vpcc_pkg;

	localparam int VALUE_BITS     = 16;
	localparam int BLACK_BITS     = 16;
	localparam int CFG_INDEX_BITS = 3;

	localparam int Q20_FRAC   = 20;
	localparam int OUT_FRAC   = 40;
	localparam int RY_BITS    = 36;
	localparam int RC_BITS    = 41;
	localparam int KW         = 23;
	localparam int PP_BITS    = 44;
	localparam int ACC_BITS   = 64;

	localparam int LIM_Y_ZERO = 4096;
	localparam int LIM_C_ZERO = 32768;
	localparam int LIM_MIN    = 256;
	localparam int LIM_MAX    = 65216;
	localparam int FULL_MAX   = 65535;
	localparam int CHROMA_SAT = 524288;

	localparam logic signed [KW-1:0] K_R_V = 23'sd1195254;
	localparam logic signed [KW-1:0] K_G_U = -23'sd413812;
	localparam logic signed [KW-1:0] K_G_V = -23'sd608826;
	localparam logic signed [KW-1:0] K_B_U = 23'sd2130771;

	typedef enum logic [1:0] {
		FMT_RGB48  = 2'd0,
		FMT_YUV444 = 2'd1,
		FMT_GRAY   = 2'd2
	} pix_fmt_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PIXEL_FORMAT = 3'd0,
		REG_BLACK_LEVEL  = 3'd1,
		REG_LUMA_GAIN    = 3'd2,
		REG_U_GAIN       = 3'd3,
		REG_V_GAIN       = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                      pad;
		logic [VALUE_BITS-1:0]     lim_y;
		logic [VALUE_BITS-1:0]     lim_cb;
		logic [VALUE_BITS-1:0]     lim_cr;
		logic [RY_BITS-1:0]        ry;
		logic signed [RC_BITS-1:0] ru;
		logic signed [RC_BITS-1:0] rv;
	} front_t;

endpackage

@@ sv/vpcc_front.sv @@
module vpcc_front #(
	parameter int SAMPLE_BITS    = 18,
	parameter int GAIN_FRAC_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                pad_pixel,
	input  logic signed [SAMPLE_BITS-1:0]       y_sample,
	input  logic signed [SAMPLE_BITS-1:0]       u_sample,
	input  logic signed [SAMPLE_BITS-1:0]       v_sample,
	input  logic [vpcc_pkg::BLACK_BITS-1:0]     black_level,
	input  logic [GAIN_FRAC_BITS+3:0]           luma_gain,
	input  logic [GAIN_FRAC_BITS+3:0]           u_gain,
	input  logic [GAIN_FRAC_BITS+3:0]           v_gain,
	output logic                                out_valid,
	input  logic                                out_stall,
	output vpcc_pkg::front_t                    out_data
);
	import vpcc_pkg::*;

	localparam int GAIN_BITS = GAIN_FRAC_BITS + 4;
	localparam int DW        = SAMPLE_BITS + 2;
	localparam int PW        = DW + GAIN_BITS + 1;
	localparam int SHL       = (GAIN_FRAC_BITS < Q20_FRAC) ? Q20_FRAC - GAIN_FRAC_BITS : 0;
	localparam int SHR       = (GAIN_FRAC_BITS > Q20_FRAC) ? GAIN_FRAC_BITS - Q20_FRAC : 0;
	localparam int QW        = PW + SHL;

	localparam logic signed [PW-1:0] RY_HI   = PW'(FULL_MAX) << GAIN_FRAC_BITS;
	localparam logic signed [PW-1:0] CSAT    = PW'(CHROMA_SAT) << GAIN_FRAC_BITS;
	localparam logic signed [PW-1:0] CSAT_N  = -CSAT;
	localparam logic signed [PW:0]   Y_OFF   = (PW+1)'(LIM_Y_ZERO) << GAIN_FRAC_BITS;
	localparam logic signed [PW:0]   C_OFF   = (PW+1)'(LIM_C_ZERO) << GAIN_FRAC_BITS;
	localparam logic signed [PW:0]   LIM_LO  = (PW+1)'(LIM_MIN) << GAIN_FRAC_BITS;
	localparam logic signed [PW:0]   LIM_HI  = (PW+1)'(LIM_MAX) << GAIN_FRAC_BITS;

	function automatic logic [VALUE_BITS-1:0] limited(input logic signed [PW-1:0] s,
			input logic signed [PW:0] off);
		logic signed [PW:0] t;
		t = (PW+1)'(s) + off;
		if (t < LIM_LO)
			limited = VALUE_BITS'(LIM_MIN);
		else if (t > LIM_HI)
			limited = VALUE_BITS'(LIM_MAX);
		else
			limited = t[GAIN_FRAC_BITS+VALUE_BITS-1:GAIN_FRAC_BITS];
	endfunction

	function automatic logic signed [RC_BITS-1:0] to_q20(input logic signed [PW-1:0] x);
		logic signed [QW-1:0] w;
		w = QW'(x);
		w = w <<< SHL;
		w = w >>> SHR;
		to_q20 = w[RC_BITS-1:0];
	endfunction

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic                   pad_s1, pad_s2;
	logic signed [DW-1:0]   ydiff_s1;
	logic signed [SAMPLE_BITS-1:0] u_s1, v_s1_smp;
	logic signed [PW-1:0]   ys_s2, us_s2, vs_s2;
	front_t                 data_s3;

	logic signed [PW-1:0]   ry_c, ru_c, rv_c;
	logic signed [RC_BITS-1:0] ry_q20;

	assign en3       = !v_s3 || !out_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign in_stall  = !en1;
	assign out_valid = v_s3;
	assign out_data  = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pad_s1   <= pad_pixel;
			ydiff_s1 <= DW'(y_sample) - DW'($signed({1'b0, black_level}));
			u_s1     <= u_sample;
			v_s1_smp <= v_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pad_s2 <= pad_s1;
			ys_s2  <= PW'(ydiff_s1) * PW'($signed({1'b0, luma_gain}));
			us_s2  <= PW'(u_s1) * PW'($signed({1'b0, u_gain}));
			vs_s2  <= PW'(v_s1_smp) * PW'($signed({1'b0, v_gain}));
		end
	end

	always_comb begin
		if (ys_s2 < 0)
			ry_c = '0;
		else if (ys_s2 > RY_HI)
			ry_c = RY_HI;
		else
			ry_c = ys_s2;

		if (us_s2 < CSAT_N)
			ru_c = CSAT_N;
		else if (us_s2 > CSAT)
			ru_c = CSAT;
		else
			ru_c = us_s2;

		if (vs_s2 < CSAT_N)
			rv_c = CSAT_N;
		else if (vs_s2 > CSAT)
			rv_c = CSAT;
		else
			rv_c = vs_s2;

		ry_q20 = to_q20(ry_c);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			data_s3.pad    <= pad_s2;
			data_s3.lim_y  <= limited(ys_s2, Y_OFF);
			data_s3.lim_cb <= limited(us_s2, C_OFF);
			data_s3.lim_cr <= limited(vs_s2, C_OFF);
			data_s3.ry     <= ry_q20[RY_BITS-1:0];
			data_s3.ru     <= to_q20(ru_c);
			data_s3.rv     <= to_q20(rv_c);
		end
	end

endmodule

@@ sv/vpcc_matrix.sv @@
module vpcc_matrix (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  vpcc_pkg::front_t                in_data,
	input  logic [1:0]                      pixel_format,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [vpcc_pkg::VALUE_BITS-1:0] first_value,
	output logic [vpcc_pkg::VALUE_BITS-1:0] second_value,
	output logic [vpcc_pkg::VALUE_BITS-1:0] third_value
);
	import vpcc_pkg::*;

	localparam int HW = RC_BITS - Q20_FRAC;
	localparam logic signed [ACC_BITS-1:0] FULL_CEIL = ACC_BITS'(FULL_MAX + 1) << OUT_FRAC;

	function automatic logic [VALUE_BITS-1:0] full_range(input logic signed [ACC_BITS-1:0] s);
		if (s < 0)
			full_range = '0;
		else if (s >= FULL_CEIL)
			full_range = VALUE_BITS'(FULL_MAX);
		else
			full_range = s[OUT_FRAC+VALUE_BITS-1:OUT_FRAC];
	endfunction

	logic v_s4, v_s5, v_s6;
	logic en4, en5, en6;

	logic signed [HW-1:0] ru_hi, rv_hi;
	logic signed [Q20_FRAC:0] ru_lo, rv_lo;

	logic                        pad_s4, pad_s5;
	logic [VALUE_BITS-1:0]       ly_s4, lcb_s4, lcr_s4, ly_s5, lcb_s5, lcr_s5;
	logic [RY_BITS-1:0]          ry_s4;
	logic signed [PP_BITS-1:0]   r_hi_s4, r_lo_s4, gu_hi_s4, gu_lo_s4;
	logic signed [PP_BITS-1:0]   gv_hi_s4, gv_lo_s4, b_hi_s4, b_lo_s4;
	logic signed [ACC_BITS-1:0]  base_s5, pr_s5, pgu_s5, pgv_s5, pb_s5;
	logic signed [ACC_BITS-1:0]  sum_r, sum_g, sum_b;
	logic [VALUE_BITS-1:0]       first_s6, second_s6, third_s6;
	logic [VALUE_BITS-1:0]       nxt_first, nxt_second, nxt_third;

	assign en6       = !v_s6 || !out_stall;
	assign en5       = !v_s5 || en6;
	assign en4       = !v_s4 || en5;
	assign in_stall  = !en4;
	assign out_valid = v_s6;

	assign first_value  = first_s6;
	assign second_value = second_s6;
	assign third_value  = third_s6;

	assign ru_hi = in_data.ru[RC_BITS-1:Q20_FRAC];
	assign rv_hi = in_data.rv[RC_BITS-1:Q20_FRAC];
	assign ru_lo = $signed({1'b0, in_data.ru[Q20_FRAC-1:0]});
	assign rv_lo = $signed({1'b0, in_data.rv[Q20_FRAC-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en4)
				v_s4 <= in_valid;
			if (en5)
				v_s5 <= v_s4;
			if (en6)
				v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			pad_s4   <= in_data.pad;
			ly_s4    <= in_data.lim_y;
			lcb_s4   <= in_data.lim_cb;
			lcr_s4   <= in_data.lim_cr;
			ry_s4    <= in_data.ry;
			r_hi_s4  <= K_R_V * rv_hi;
			r_lo_s4  <= K_R_V * rv_lo;
			gu_hi_s4 <= K_G_U * ru_hi;
			gu_lo_s4 <= K_G_U * ru_lo;
			gv_hi_s4 <= K_G_V * rv_hi;
			gv_lo_s4 <= K_G_V * rv_lo;
			b_hi_s4  <= K_B_U * ru_hi;
			b_lo_s4  <= K_B_U * ru_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			pad_s5  <= pad_s4;
			ly_s5   <= ly_s4;
			lcb_s5  <= lcb_s4;
			lcr_s5  <= lcr_s4;
			base_s5 <= ACC_BITS'({ry_s4, {Q20_FRAC{1'b0}}});
			pr_s5   <= (ACC_BITS'(r_hi_s4) <<< Q20_FRAC) + ACC_BITS'(r_lo_s4);
			pgu_s5  <= (ACC_BITS'(gu_hi_s4) <<< Q20_FRAC) + ACC_BITS'(gu_lo_s4);
			pgv_s5  <= (ACC_BITS'(gv_hi_s4) <<< Q20_FRAC) + ACC_BITS'(gv_lo_s4);
			pb_s5   <= (ACC_BITS'(b_hi_s4) <<< Q20_FRAC) + ACC_BITS'(b_lo_s4);
		end
	end

	always_comb begin
		sum_r = base_s5 + pr_s5;
		sum_g = base_s5 + pgu_s5 + pgv_s5;
		sum_b = base_s5 + pb_s5;
		nxt_first  = '0;
		nxt_second = '0;
		nxt_third  = '0;
		case (pixel_format)
			FMT_RGB48: begin
				if (!pad_s5) begin
					nxt_first  = full_range(sum_r);
					nxt_second = full_range(sum_g);
					nxt_third  = full_range(sum_b);
				end
			end
			FMT_YUV444: begin
				if (pad_s5) begin
					nxt_first  = VALUE_BITS'(LIM_Y_ZERO);
					nxt_second = VALUE_BITS'(LIM_C_ZERO);
					nxt_third  = VALUE_BITS'(LIM_C_ZERO);
				end else begin
					nxt_first  = ly_s5;
					nxt_second = lcb_s5;
					nxt_third  = lcr_s5;
				end
			end
			FMT_GRAY: begin
				nxt_first = pad_s5 ? VALUE_BITS'(LIM_Y_ZERO) : ly_s5;
			end
			default: begin
				nxt_first = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			first_s6  <= nxt_first;
			second_s6 <= nxt_second;
			third_s6  <= nxt_third;
		end
	end

endmodule

@@ sv/video_pixel_colour_converter.sv @@
// Six-stage pixel pipeline: subtract, multiply, clamp, matrix partial products,
// partial-product merge, final sum and clamp.
// Throughput: one pixel per cycle while result_stall is low, when every stage
// takes a new pixel each cycle; stalled stages hold while empty ones upstream
// still fill.
// Reset clears all valid bits and loads the configuration registers with their defaults.
module video_pixel_colour_converter #(
	parameter int SAMPLE_BITS    = 18,
	parameter int GAIN_FRAC_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pixel_valid,
	output logic                                  pixel_stall,
	input  logic                                  pad_pixel,
	input  logic signed [SAMPLE_BITS-1:0]         y_sample,
	input  logic signed [SAMPLE_BITS-1:0]         u_sample,
	input  logic signed [SAMPLE_BITS-1:0]         v_sample,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [vpcc_pkg::VALUE_BITS-1:0]       first_value,
	output logic [vpcc_pkg::VALUE_BITS-1:0]       second_value,
	output logic [vpcc_pkg::VALUE_BITS-1:0]       third_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vpcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [GAIN_FRAC_BITS+3:0]             cfg_data
);
	import vpcc_pkg::*;

	localparam int GAIN_BITS = GAIN_FRAC_BITS + 4;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;

	logic [1:0]            pixel_format_q;
	logic [BLACK_BITS-1:0] black_level_q;
	logic [GAIN_BITS-1:0]  luma_gain_q, u_gain_q, v_gain_q;

	logic   front_valid, front_stall;
	front_t front_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGB48;
			black_level_q  <= '0;
			luma_gain_q    <= GAIN_ONE;
			u_gain_q       <= GAIN_ONE;
			v_gain_q       <= GAIN_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[1:0];
				REG_BLACK_LEVEL:  black_level_q  <= cfg_data[BLACK_BITS-1:0];
				REG_LUMA_GAIN:    luma_gain_q    <= cfg_data;
				REG_U_GAIN:       u_gain_q       <= cfg_data;
				REG_V_GAIN:       v_gain_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vpcc_front #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pixel_valid),
		.in_stall    (pixel_stall),
		.pad_pixel   (pad_pixel),
		.y_sample    (y_sample),
		.u_sample    (u_sample),
		.v_sample    (v_sample),
		.black_level (black_level_q),
		.luma_gain   (luma_gain_q),
		.u_gain      (u_gain_q),
		.v_gain      (v_gain_q),
		.out_valid   (front_valid),
		.out_stall   (front_stall),
		.out_data    (front_data)
	);

	vpcc_matrix u_matrix (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (front_valid),
		.in_stall     (front_stall),
		.in_data      (front_data),
		.pixel_format (pixel_format_q),
		.out_valid    (result_valid),
		.out_stall    (result_stall),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value)
	);

endmodule

@@ sv/vpcc_checker.sv @@
module vpcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pixel_valid,
	input logic        pixel_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] first_value,
	input logic [15:0] second_value,
	input logic [15:0] third_value
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			$stable(first_value) && $stable(second_value) && $stable(third_value))
		else $error("result payload changed while stalled");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) ##1 !result_stall ##1 !result_stall
			##1 !result_stall ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("transferred pixel missing at the output");

endmodule

bind video_pixel_colour_converter vpcc_checker u_vpcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_stall  (pixel_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.first_value  (first_value),
	.second_value (second_value),
	.third_value  (third_value)
);

@@ verif/video_pixel_colour_converter_test.sv @@
`timescale 1ns / 100ps

module video_pixel_colour_converter_test;
	import vpcc_pkg::*;

	localparam int SAMPLE_W = 18;
	localparam int GAIN_FRAC = 20;
	localparam int GAIN_W = GAIN_FRAC + 4;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int RANDOM_PHASES = 10;
	localparam int PRESSURE_PHASE = 5;
	localparam int PRESSURE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;

	localparam logic [1:0] FMT_UNUSED = 2'd3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [GAIN_W-1:0] gain_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam gain_t GAIN_MAX = '1;
	localparam gain_t GAIN_ONE = gain_t'(1) << GAIN_FRAC;
	localparam logic [BLACK_BITS-1:0] BLACK_MAX = '1;

	typedef struct {
		logic    pad;
		sample_t y;
		sample_t u;
		sample_t v;
	} pixel_t;

	typedef struct {
		logic [VALUE_BITS-1:0] first;
		logic [VALUE_BITS-1:0] second;
		logic [VALUE_BITS-1:0] third;
	} colour_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic pad_pixel = 1'b0;
	sample_t y_sample = '0;
	sample_t u_sample = '0;
	sample_t v_sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [VALUE_BITS-1:0] first_value;
	logic [VALUE_BITS-1:0] second_value;
	logic [VALUE_BITS-1:0] third_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	gain_t cfg_data = '0;

	logic [1:0] fmt_reg = FMT_RGB48;
	logic [BLACK_BITS-1:0] black_reg = '0;
	gain_t luma_gain_reg = GAIN_ONE;
	gain_t u_gain_reg = GAIN_ONE;
	gain_t v_gain_reg = GAIN_ONE;

	pixel_t pending_pixels[$];
	colour_t expected_colours[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pressure_on = 1'b0;
	bit pressure_done = 1'b0;
	int hold_left = 0;
	int failures = 0;
	int quiet_cycles = 0;

	video_pixel_colour_converter #(
		.SAMPLE_BITS(SAMPLE_W),
		.GAIN_FRAC_BITS(GAIN_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pad_pixel(pad_pixel),
		.y_sample(y_sample),
		.u_sample(u_sample),
		.v_sample(v_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.first_value(first_value),
		.second_value(second_value),
		.third_value(third_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clamp(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic longint to_q20(longint x);
		if (GAIN_FRAC < Q20_FRAC)
			return x <<< (Q20_FRAC - GAIN_FRAC);
		return x >>> (GAIN_FRAC - Q20_FRAC);
	endfunction

	function automatic logic [VALUE_BITS-1:0] limited(longint scaled, longint zero);
		longint one;
		longint t;
		one = longint'(1) << GAIN_FRAC;
		t = clamp(scaled + zero * one, longint'(LIM_MIN) * one, longint'(LIM_MAX) * one);
		return VALUE_BITS'(t >>> GAIN_FRAC);
	endfunction

	function automatic logic [VALUE_BITS-1:0] full_range(longint q40);
		longint v;
		if (q40 < 0)
			return '0;
		v = q40 >>> OUT_FRAC;
		return (v > FULL_MAX) ? VALUE_BITS'(FULL_MAX) : VALUE_BITS'(v);
	endfunction

	function automatic colour_t convert_pixel(pixel_t p);
		longint one;
		longint sat;
		longint ys;
		longint us;
		longint vs;
		longint ry;
		longint ru;
		longint rv;
		longint base;
		colour_t c;
		one = longint'(1) << GAIN_FRAC;
		sat = longint'(CHROMA_SAT) * one;
		ys = (longint'(p.y) - longint'(black_reg)) * longint'(luma_gain_reg);
		us = longint'(p.u) * longint'(u_gain_reg);
		vs = longint'(p.v) * longint'(v_gain_reg);
		c.first = '0;
		c.second = '0;
		c.third = '0;
		case (fmt_reg)
			FMT_RGB48: if (!p.pad) begin
				ry = to_q20(clamp(ys, 0, longint'(FULL_MAX) * one));
				ru = to_q20(clamp(us, -sat, sat));
				rv = to_q20(clamp(vs, -sat, sat));
				base = ry <<< Q20_FRAC;
				c.first = full_range(base + longint'(K_R_V) * rv);
				c.second = full_range(base + longint'(K_G_U) * ru + longint'(K_G_V) * rv);
				c.third = full_range(base + longint'(K_B_U) * ru);
			end
			FMT_YUV444: if (p.pad) begin
				c.first = VALUE_BITS'(LIM_Y_ZERO);
				c.second = VALUE_BITS'(LIM_C_ZERO);
				c.third = VALUE_BITS'(LIM_C_ZERO);
			end else begin
				c.first = limited(ys, LIM_Y_ZERO);
				c.second = limited(us, LIM_C_ZERO);
				c.third = limited(vs, LIM_C_ZERO);
			end
			FMT_GRAY: begin
				c.first = p.pad ? VALUE_BITS'(LIM_Y_ZERO) : limited(ys, LIM_Y_ZERO);
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(5, 0))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return sample_t'(int'($urandom_range(1024, 0)) - 512);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic gain_t pick_gain();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return GAIN_MAX;
			2, 3: return gain_t'(int'(GAIN_ONE) + int'($urandom_range(524288, 0)) - 262144);
			default: return gain_t'($urandom);
		endcase
	endfunction

	function automatic logic [BLACK_BITS-1:0] pick_black();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return BLACK_MAX;
			default: return BLACK_BITS'($urandom);
		endcase
	endfunction

	task automatic write_register(cfg_reg_t idx, gain_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PIXEL_FORMAT: fmt_reg = data[1:0];
			REG_BLACK_LEVEL: black_reg = data[BLACK_BITS-1:0];
			REG_LUMA_GAIN: luma_gain_reg = data;
			REG_U_GAIN: u_gain_reg = data;
			REG_V_GAIN: v_gain_reg = data;
			default: ;
		endcase
	endtask

	task automatic load_setting(logic [1:0] fmt, logic [BLACK_BITS-1:0] blk, gain_t lg,
			gain_t ug, gain_t vg);
		write_register(REG_PIXEL_FORMAT, gain_t'(fmt));
		write_register(REG_BLACK_LEVEL, gain_t'(blk));
		write_register(REG_LUMA_GAIN, lg);
		write_register(REG_U_GAIN, ug);
		write_register(REG_V_GAIN, vg);
	endtask

	task automatic queue_pixel(logic pad, sample_t y, sample_t u, sample_t v);
		pixel_t px;
		px = '{pad, y, u, v};
		pending_pixels.insert(pending_pixels.size(), px);
	endtask

	task automatic wait_drain();
		while (pending_pixels.size() != 0 || pixel_valid || expected_colours.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pad_pixel <= 1'b0;
			y_sample <= '0;
			u_sample <= '0;
			v_sample <= '0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				expected_colours.insert(expected_colours.size(),
					convert_pixel(pending_pixels[0]));
				void'(pending_pixels.pop_front());
			end
			// hold a stalled transfer
			if (!pixel_valid || !pixel_stall) begin
				if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					pixel_valid <= 1'b1;
					pad_pixel <= pending_pixels[0].pad;
					y_sample <= pending_pixels[0].y;
					u_sample <= pending_pixels[0].u;
					v_sample <= pending_pixels[0].v;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		colour_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_colours.size() == 0) begin
					$error("result transfer with no expected colour pending");
					failures++;
				end else begin
					want = expected_colours.pop_front();
					if (first_value !== want.first) begin
						$error("first_value: expected %0d, got %0d", want.first, first_value);
						failures++;
					end
					if (second_value !== want.second) begin
						$error("second_value: expected %0d, got %0d", want.second, second_value);
						failures++;
					end
					if (third_value !== want.third) begin
						$error("third_value: expected %0d, got %0d", want.third, third_value);
						failures++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (pressure_on && !pressure_done) begin
				hold_left = PRESSURE_CYCLES;
				pressure_done = 1'b1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int r;
		int blk;
		int fmt;
		bit realistic;
		gain_t lg;
		gain_t cg;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// defaults after reset: RGB48, unit gains
		queue_pixel(1'b0, '0, '0, '0);
		queue_pixel(1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		queue_pixel(1'b0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		queue_pixel(1'b1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
		queue_pixel(1'b0, sample_t'(40000), SAMPLE_MAX, SAMPLE_MIN);
		wait_drain();

		// saturated chroma in the matrix
		load_setting(FMT_RGB48, '0, GAIN_ONE, GAIN_MAX, GAIN_MAX);
		queue_pixel(1'b0, sample_t'(65535), SAMPLE_MAX, SAMPLE_MIN);
		queue_pixel(1'b0, sample_t'(30000), SAMPLE_MAX, SAMPLE_MAX);
		queue_pixel(1'b0, sample_t'(30000), SAMPLE_MIN, SAMPLE_MIN);
		wait_drain();

		load_setting(FMT_YUV444, '0, GAIN_ONE, GAIN_ONE, GAIN_ONE);
		queue_pixel(1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		queue_pixel(1'b0, '0, '0, '0);
		queue_pixel(1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		queue_pixel(1'b0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		wait_drain();

		load_setting(FMT_GRAY, BLACK_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
		queue_pixel(1'b1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
		queue_pixel(1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		queue_pixel(1'b0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		wait_drain();

		load_setting(FMT_UNUSED, '0, GAIN_ONE, GAIN_ONE, GAIN_ONE);
		queue_pixel(1'b1, SAMPLE_MAX, '0, '0);
		queue_pixel(1'b0, sample_t'(30000), sample_t'(1000), SAMPLE_MIN);
		wait_drain();

		// zero gains leave only offsets
		load_setting(FMT_YUV444, BLACK_MAX, '0, '0, '0);
		queue_pixel(1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
		queue_pixel(1'b0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
		wait_drain();
		write_register(REG_PIXEL_FORMAT, gain_t'(FMT_RGB48));
		queue_pixel(1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		wait_drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			realistic = (p % 2 == 0);
			r = int'($urandom_range(60000, 4096));
			if (realistic) begin
				blk = int'($urandom_range(20000, 0));
				fmt = int'($urandom_range(2, 0));
				lg = gain_t'(((fmt == FMT_RGB48) ? (longint'(65535) << GAIN_FRAC) :
					(longint'(56064) << GAIN_FRAC)) / r);
				cg = (fmt == FMT_RGB48) ? lg : (lg >> 1);
				load_setting(2'(fmt), BLACK_BITS'(blk), lg, cg,
					gain_t'(cg + $urandom_range(4096, 0)));
			end else begin
				blk = int'(pick_black());
				fmt = ($urandom_range(4, 0) == 0) ? int'(FMT_UNUSED) :
					int'($urandom_range(2, 0));
				load_setting(2'(fmt), BLACK_BITS'(blk), pick_gain(), pick_gain(),
					pick_gain());
				write_register(cfg_reg_t'($urandom_range(7, 5)), gain_t'($urandom));
			end
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 54; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 54; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			@(negedge clk);
			repeat (ITEMS_PER_PHASE) begin
				if (realistic)
					queue_pixel($urandom_range(9, 0) == 0,
						sample_t'(blk + int'($urandom_range(r, 0)) +
							int'($urandom_range(400, 0)) - 200),
						sample_t'(int'($urandom_range(r, 0)) - r / 2),
						sample_t'(int'($urandom_range(r, 0)) - r / 2));
				else
					queue_pixel($urandom_range(9, 0) == 0, pick_sample(), pick_sample(),
						pick_sample());
			end
			if (p == PRESSURE_PHASE) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				pressure_on = 1'b1;
			end
			wait_drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_colours.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
sv/vpcc_pkg.sv
sv/vpcc_front.sv
sv/vpcc_matrix.sv
sv/video_pixel_colour_converter.sv
sv/vpcc_checker.sv
verif/video_pixel_colour_converter_test.sv
